@@ rtl/mcur_pkg.sv @@
`default_nettype none
package mcur_pkg;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_TICKS_PER_MS        = 2'd0;
    localparam logic [1:0] REG_HOLDOFF_MS          = 2'd1;
    localparam logic [1:0] REG_TRIGGER_WIDTH_TICKS = 2'd2;

    localparam logic [15:0] TICKS_PER_MS_RESET        = 16'd1000;
    localparam logic [15:0] HOLDOFF_MS_RESET          = 16'd60;
    localparam logic [7:0]  TRIGGER_WIDTH_TICKS_RESET = 8'd15;

    // Last trigger time starts one full holdoff in the past
    localparam logic [31:0] HOLDOFF_RESET_OFFSET = 32'd60;
    localparam logic [31:0] LAST_TRIGGER_RESET   = 32'd0 - HOLDOFF_RESET_OFFSET;

    localparam int unsigned CM_DIVISOR = 59;
    localparam int unsigned DIST_BITS  = 11;
    localparam logic [DIST_BITS-1:0] DIST_MAX = 11'd2047;
    localparam int unsigned SEL_BITS   = 3;

    typedef struct packed {
        logic [15:0] ticks_per_ms;
        logic [15:0] holdoff_ms;
        logic [7:0]  trigger_width_ticks;
    } cfg_t;

    typedef struct packed {
        logic trigger;
        logic updated;
    } lane_flags_t;

endpackage
`default_nettype wire

@@ rtl/mcur_lane.sv @@
`default_nettype none
module mcur_lane #(
    parameter int WIDTH_BITS = 16
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     fire,
    input  mcur_pkg::cfg_t          cfg,
    input  wire [31:0]              us_time,
    input  wire [31:0]              ms_time,
    input  wire                     echo_level,
    input  wire                     start_request,
    output mcur_pkg::lane_flags_t   flags_o,
    output logic [WIDTH_BITS-1:0]   width_o
);

    localparam logic [WIDTH_BITS-1:0] WMAX = {WIDTH_BITS{1'b1}};

    logic                  echo_prev_reg;
    logic [31:0]           rise_reg;
    logic [31:0]           rise_next;
    logic [WIDTH_BITS-1:0] width_reg;
    logic [WIDTH_BITS-1:0] width_next;
    logic [31:0]           last_trig_reg;
    logic [31:0]           last_trig_next;
    logic [7:0]            count_reg;
    logic [7:0]            count_next;

    logic [31:0] holdoff_limit;
    logic        accept_req;
    logic [7:0]  count_loaded;
    logic        trigger;
    logic        rising;
    logic        falling;
    logic [31:0] pulse;
    logic        stored;

    always_comb begin
        holdoff_limit  = last_trig_reg + {16'd0, cfg.holdoff_ms};
        accept_req     = start_request && !(ms_time < holdoff_limit);
        count_loaded   = accept_req ? cfg.trigger_width_ticks : count_reg;
        trigger        = (count_loaded != 8'd0);
        count_next     = trigger ? count_loaded - 8'd1 : count_loaded;
        last_trig_next = accept_req ? ms_time : last_trig_reg;

        rising    = echo_level && !echo_prev_reg;
        falling   = !echo_level && echo_prev_reg;
        pulse     = us_time - rise_reg;
        stored    = falling && (us_time > rise_reg);
        rise_next = rising ? us_time : rise_reg;
        if (stored) begin
            width_next = (pulse > 32'(WMAX)) ? WMAX : pulse[WIDTH_BITS-1:0];
        end else begin
            width_next = width_reg;
        end
    end

    assign flags_o.trigger = trigger;
    assign flags_o.updated = stored;
    assign width_o         = width_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            echo_prev_reg <= 1'b0;
            rise_reg      <= 32'd0;
            width_reg     <= '0;
            last_trig_reg <= mcur_pkg::LAST_TRIGGER_RESET;
            count_reg     <= 8'd0;
        end else if (fire) begin
            echo_prev_reg <= echo_level;
            rise_reg      <= rise_next;
            width_reg     <= width_next;
            last_trig_reg <= last_trig_next;
            count_reg     <= count_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/mcur_merge.sv @@
`default_nettype none
module mcur_merge #(
    parameter int CHANNELS   = 6,
    parameter int WIDTH_BITS = 16
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  fire,
    output logic                                 ready,
    input  mcur_pkg::lane_flags_t                flags_i [CHANNELS],
    input  wire [WIDTH_BITS-1:0]                 width_i [CHANNELS],
    input  wire [mcur_pkg::SEL_BITS-1:0]         read_channel,
    output logic                                 m_valid,
    input  wire                                  m_ready,
    output logic [CHANNELS-1:0]                  trigger_lines,
    output logic [mcur_pkg::DIST_BITS-1:0]       distance_cm,
    output logic [CHANNELS-1:0]                  updated_channels
);

    localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SHIFT  = WIDTH_BITS + 6;
    localparam int RECIP_W = WIDTH_BITS + 1;
    localparam longint unsigned RECIP =
        ((64'd1 << SHIFT) + mcur_pkg::CM_DIVISOR - 1) / mcur_pkg::CM_DIVISOR;
    localparam int PROD_W = WIDTH_BITS + RECIP_W;

    logic                  s1_valid_reg;
    logic [CHANNELS-1:0]   s1_trig_reg;
    logic [CHANNELS-1:0]   s1_upd_reg;
    logic [WIDTH_BITS-1:0] s1_width_reg;
    logic                  s1_sel_ok_reg;

    logic                           m_valid_reg;
    logic [CHANNELS-1:0]            m_trig_reg;
    logic [CHANNELS-1:0]            m_upd_reg;
    logic [mcur_pkg::DIST_BITS-1:0] m_dist_reg;
    logic [mcur_pkg::DIST_BITS-1:0] m_dist_next;

    logic                  adv2;
    logic                  adv1;
    logic [CHANNELS-1:0]   trig_vec;
    logic [CHANNELS-1:0]   upd_vec;
    logic                  sel_ok;
    logic [WIDTH_BITS-1:0] width_sel;
    logic [PROD_W-1:0]     product;
    logic [PROD_W-1:0]     quotient;

    always_comb begin
        for (int i = 0; i < CHANNELS; i++) begin
            trig_vec[i] = flags_i[i].trigger;
            upd_vec[i]  = flags_i[i].updated;
        end
        sel_ok    = ({1'b0, read_channel} < 4'(CHANNELS));
        width_sel = sel_ok ? width_i[read_channel[IDX_W-1:0]] : '0;
    end

    // Divide by the constant through a reciprocal multiply
    always_comb begin
        product  = PROD_W'(s1_width_reg) * PROD_W'(RECIP);
        quotient = product >> SHIFT;
        if (!s1_sel_ok_reg) begin
            m_dist_next = '0;
        end else if (quotient > PROD_W'(mcur_pkg::DIST_MAX)) begin
            m_dist_next = mcur_pkg::DIST_MAX;
        end else begin
            m_dist_next = quotient[mcur_pkg::DIST_BITS-1:0];
        end
    end

    assign adv2  = !m_valid_reg || m_ready;
    assign adv1  = !s1_valid_reg || adv2;
    assign ready = adv1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (adv1) begin
                s1_valid_reg <= fire;
            end
            if (adv2) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            s1_trig_reg   <= trig_vec;
            s1_upd_reg    <= upd_vec;
            s1_width_reg  <= width_sel;
            s1_sel_ok_reg <= sel_ok;
        end
        if (adv2 && s1_valid_reg) begin
            m_trig_reg <= s1_trig_reg;
            m_upd_reg  <= s1_upd_reg;
            m_dist_reg <= m_dist_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign trigger_lines    = m_trig_reg;
    assign distance_cm      = m_dist_reg;
    assign updated_channels = m_upd_reg;

endmodule
`default_nettype wire

@@ rtl/multi_channel_ultrasonic_ranger_top.sv @@
`default_nettype none
// Pipeline: a result is registered in the s1 stage and then in the output stage.
// Throughput: one tick per cycle while the output is not stalled; the lanes
// keep per-channel state; the reciprocal multiply sits in its own output stage.
// Reset: aresetn is synchronous, active low; it clears the time counters and all
// channel state and loads the register defaults. No clearing pass is needed.
module multi_channel_ultrasonic_ranger_top #(
    parameter int CHANNELS   = 6,
    parameter int WIDTH_BITS = 16
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    // echo_levels, start_requests, read_channel, zero fill
    input  wire [((2*CHANNELS+mcur_pkg::SEL_BITS+7)/8)*8-1:0] s_tdata,
    output logic        m_tvalid,
    input  wire         m_tready,
    // trigger_lines, distance_cm, updated_channels, zero fill
    output logic [((2*CHANNELS+mcur_pkg::DIST_BITS+7)/8)*8-1:0] m_tdata,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire [3:0]   paddr,
    input  wire [31:0]  pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int OUT_BITS = 2*CHANNELS + mcur_pkg::DIST_BITS;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    mcur_pkg::cfg_t cfg_reg;
    logic [31:0]    us_reg;
    logic [31:0]    ms_reg;
    logic [15:0]    presc_reg;
    logic [15:0]    presc_next;
    logic [31:0]    ms_next;
    logic [15:0]    tpm_eff;

    logic s_fire;
    logic ready;
    logic cfg_write;

    logic [CHANNELS-1:0]             echo_levels;
    logic [CHANNELS-1:0]             start_requests;
    logic [mcur_pkg::SEL_BITS-1:0]   read_channel;
    logic [CHANNELS-1:0]             trigger_lines;
    logic [mcur_pkg::DIST_BITS-1:0]  distance_cm;
    logic [CHANNELS-1:0]             updated_channels;

    mcur_pkg::lane_flags_t lane_flags [CHANNELS];
    logic [WIDTH_BITS-1:0] lane_width [CHANNELS];

    assign echo_levels    = s_tdata[CHANNELS-1:0];
    assign start_requests = s_tdata[2*CHANNELS-1:CHANNELS];
    assign read_channel   = s_tdata[2*CHANNELS+mcur_pkg::SEL_BITS-1:2*CHANNELS];

    assign s_tready = ready;
    assign s_fire   = s_tvalid && ready;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ticks_per_ms        <= mcur_pkg::TICKS_PER_MS_RESET;
            cfg_reg.holdoff_ms          <= mcur_pkg::HOLDOFF_MS_RESET;
            cfg_reg.trigger_width_ticks <= mcur_pkg::TRIGGER_WIDTH_TICKS_RESET;
        end else if (cfg_write) begin
            case (paddr[3:2])
                mcur_pkg::REG_TICKS_PER_MS:        cfg_reg.ticks_per_ms <= pwdata[15:0];
                mcur_pkg::REG_HOLDOFF_MS:          cfg_reg.holdoff_ms <= pwdata[15:0];
                mcur_pkg::REG_TRIGGER_WIDTH_TICKS: begin
                    cfg_reg.trigger_width_ticks <= pwdata[7:0];
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            mcur_pkg::REG_TICKS_PER_MS:        prdata = {16'd0, cfg_reg.ticks_per_ms};
            mcur_pkg::REG_HOLDOFF_MS:          prdata = {16'd0, cfg_reg.holdoff_ms};
            mcur_pkg::REG_TRIGGER_WIDTH_TICKS: prdata = {24'd0, cfg_reg.trigger_width_ticks};
            default:                           prdata = 32'd0;
        endcase
    end

    // Time base: a tick rate of zero counts as one
    always_comb begin
        tpm_eff = (cfg_reg.ticks_per_ms == 16'd0) ? 16'd1 : cfg_reg.ticks_per_ms;
        if (({1'b0, presc_reg} + 17'd1) >= {1'b0, tpm_eff}) begin
            presc_next = 16'd0;
            ms_next    = ms_reg + 32'd1;
        end else begin
            presc_next = presc_reg + 16'd1;
            ms_next    = ms_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            us_reg    <= 32'd0;
            ms_reg    <= 32'd0;
            presc_reg <= 16'd0;
        end else if (s_fire) begin
            us_reg    <= us_reg + 32'd1;
            ms_reg    <= ms_next;
            presc_reg <= presc_next;
        end
    end

    for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
        mcur_lane #(
            .WIDTH_BITS (WIDTH_BITS)
        ) u_lane (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .fire          (s_fire),
            .cfg           (cfg_reg),
            .us_time       (us_reg),
            .ms_time       (ms_reg),
            .echo_level    (echo_levels[c]),
            .start_request (start_requests[c]),
            .flags_o       (lane_flags[c]),
            .width_o       (lane_width[c])
        );
    end

    mcur_merge #(
        .CHANNELS   (CHANNELS),
        .WIDTH_BITS (WIDTH_BITS)
    ) u_merge (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .fire             (s_fire),
        .ready            (ready),
        .flags_i          (lane_flags),
        .width_i          (lane_width),
        .read_channel     (read_channel),
        .m_valid          (m_tvalid),
        .m_ready          (m_tready),
        .trigger_lines    (trigger_lines),
        .distance_cm      (distance_cm),
        .updated_channels (updated_channels)
    );

    assign m_tdata = {(OUT_W-OUT_BITS)'(0), updated_channels, distance_cm, trigger_lines};

`ifndef SYNTHESIS
    // Input stalls only when a result is held back downstream
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output backpressure");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> (us_reg == $past(us_reg) + 32'd1))
        else $error("microsecond counter did not advance on transfer");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_fire |=> ($stable(us_reg) && $stable(ms_reg) && $stable(presc_reg)))
        else $error("time base moved without an input transfer");
`endif

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
module tb_top;

    localparam int NCH   = 6;
    localparam int WBITS = 16;
    localparam int SW    = ((2*NCH+mcur_pkg::SEL_BITS+7)/8)*8;
    localparam int MW    = ((2*NCH+mcur_pkg::DIST_BITS+7)/8)*8;
    localparam logic [31:0] WIDTH_MAX = (32'd1 << WBITS) - 32'd1;
    localparam int LONG_HOLD   = 300;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int LONG_ECHO_TICKS = 60;

    typedef struct packed {
        logic [NCH-1:0]                 trig;
        logic [mcur_pkg::DIST_BITS-1:0] dist_cm;
        logic [NCH-1:0]                 upd;
    } ranger_out_t;

    logic          aclk = 1'b0;
    logic          aresetn;
    logic          s_tvalid;
    wire           s_tready;
    // echo_levels, start_requests, read_channel, zero fill
    logic [SW-1:0] s_tdata;
    wire           m_tvalid;
    logic          m_tready;
    // trigger_lines, distance_cm, updated_channels, zero fill
    wire  [MW-1:0] m_tdata;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [3:0]    paddr;
    logic [31:0]   pwdata;
    wire  [31:0]   prdata;
    wire           pready;

    multi_channel_ultrasonic_ranger_top #(
        .CHANNELS  (NCH),
        .WIDTH_BITS(WBITS)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #4 aclk = ~aclk;

    // Predicted ranger state
    mcur_pkg::cfg_t    cfg_model;
    logic [31:0]       us_time;
    logic [31:0]       ms_time;
    logic [15:0]       ms_presc;
    logic [NCH-1:0]    echo_prev;
    logic [31:0]       rise_at     [NCH];
    logic [WBITS-1:0]  width_store [NCH];
    logic [31:0]       last_trig   [NCH];
    logic [7:0]        trig_left   [NCH];

    ranger_out_t expected_outs[$];
    int          mismatches = 0;
    int          cycle_count = 0;
    bit          src_idle_en = 1'b1;
    bit          sink_idle_en = 1'b1;
    int          hold_requests = 0;

    // Echo waveform generator state
    logic [NCH-1:0] gen_level = '0;
    int             echo_hold [NCH];

    function automatic void reset_model();
        cfg_model.ticks_per_ms        = mcur_pkg::TICKS_PER_MS_RESET;
        cfg_model.holdoff_ms          = mcur_pkg::HOLDOFF_MS_RESET;
        cfg_model.trigger_width_ticks = mcur_pkg::TRIGGER_WIDTH_TICKS_RESET;
        us_time   = '0;
        ms_time   = '0;
        ms_presc  = '0;
        echo_prev = '0;
        for (int c = 0; c < NCH; c++) begin
            rise_at[c]     = '0;
            width_store[c] = '0;
            last_trig[c]   = mcur_pkg::LAST_TRIGGER_RESET;
            trig_left[c]   = '0;
        end
    endfunction

    function automatic ranger_out_t predict_tick(input logic [NCH-1:0] echo,
                                                 input logic [NCH-1:0] req,
                                                 input logic [2:0] sel);
        ranger_out_t r;
        logic [31:0] limit;
        logic [31:0] w;
        logic [31:0] d;
        logic [31:0] tpm;
        r = '0;
        for (int c = 0; c < NCH; c++) begin
            if (req[c]) begin
                limit = last_trig[c] + {16'd0, cfg_model.holdoff_ms};
                if (!(ms_time < limit)) begin
                    last_trig[c] = ms_time;
                    trig_left[c] = cfg_model.trigger_width_ticks;
                end
            end
            if (trig_left[c] != 8'd0) begin
                r.trig[c]    = 1'b1;
                trig_left[c] = trig_left[c] - 8'd1;
            end
            if (echo[c] && !echo_prev[c]) begin
                rise_at[c] = us_time;
            end else if (!echo[c] && echo_prev[c] && us_time > rise_at[c]) begin
                w = us_time - rise_at[c];
                width_store[c] = (w > WIDTH_MAX) ? WIDTH_MAX[WBITS-1:0] : w[WBITS-1:0];
                r.upd[c] = 1'b1;
            end
            echo_prev[c] = echo[c];
        end
        if (sel < NCH) begin
            d = 32'(width_store[sel]) / mcur_pkg::CM_DIVISOR;
            r.dist_cm = (d > 32'(mcur_pkg::DIST_MAX)) ? mcur_pkg::DIST_MAX
                                                      : d[mcur_pkg::DIST_BITS-1:0];
        end
        us_time = us_time + 32'd1;
        tpm = (cfg_model.ticks_per_ms == 16'd0) ? 32'd1 : {16'd0, cfg_model.ticks_per_ms};
        if ({16'd0, ms_presc} + 32'd1 >= tpm) begin
            ms_presc = '0;
            ms_time  = ms_time + 32'd1;
        end else begin
            ms_presc = ms_presc + 16'd1;
        end
        return r;
    endfunction

    function automatic logic [NCH-1:0] next_echo_levels();
        logic [NCH-1:0] lv;
        for (int c = 0; c < NCH; c++) begin
            if (echo_hold[c] == 0) begin
                gen_level[c] = ~gen_level[c];
                if (gen_level[c])
                    echo_hold[c] = ($urandom_range(0, 9) == 0) ? $urandom_range(300, 1500)
                                                                : $urandom_range(1, 250);
                else
                    echo_hold[c] = $urandom_range(1, 60);
            end
            echo_hold[c] = echo_hold[c] - 1;
            lv[c] = gen_level[c];
        end
        // occasional glitchy pin levels
        if ($urandom_range(0, 11) == 0)
            lv = NCH'($urandom);
        return lv;
    endfunction

    task automatic send_tick(input logic [NCH-1:0] echo, input logic [NCH-1:0] req,
                             input logic [2:0] sel);
        int gap;
        if (src_idle_en && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 17);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= SW'({sel, req, echo});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_outs.push_back(predict_tick(echo, req, sel));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_outs.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic program_ranger(input logic [15:0] tpm, input logic [15:0] hold,
                                  input logic [7:0] width);
        drain_results();
        apb_write(mcur_pkg::REG_TICKS_PER_MS, {16'd0, tpm});
        cfg_model.ticks_per_ms = tpm;
        apb_write(mcur_pkg::REG_HOLDOFF_MS, {16'd0, hold});
        cfg_model.holdoff_ms = hold;
        apb_write(mcur_pkg::REG_TRIGGER_WIDTH_TICKS, {24'd0, width});
        cfg_model.trigger_width_ticks = width;
    endtask

    task automatic random_ticks(input int n);
        logic [NCH-1:0] req;
        for (int i = 0; i < n; i++) begin
            req = '0;
            for (int c = 0; c < NCH; c++)
                if ($urandom_range(0, 9) == 0) req[c] = 1'b1;
            if ($urandom_range(0, 29) == 0) req = '1;
            send_tick(next_echo_levels(), req, 3'($urandom_range(0, 7)));
        end
    endtask

    task automatic test_defaults();
        // reset offset lets the first request through, the second hits holdoff
        send_tick(6'h3F, 6'h3F, 3'd0);
        send_tick(6'h00, 6'h3F, 3'd7);
        send_tick(6'h2A, 6'h00, 3'd4);
        send_tick(6'h15, 6'h00, 3'd6);
    endtask

    task automatic test_register_extremes();
        // zero tick rate, no holdoff, widest pulse; request reloads a running pulse
        program_ranger(16'd0, 16'd0, 8'd255);
        send_tick(6'h3F, 6'h3F, 3'd3);
        send_tick(6'h00, 6'h00, 3'd5);
        send_tick(6'h3F, 6'h2A, 3'd1);
        // zero width: request accepted but the pulse stops
        program_ranger(16'd65535, 16'd0, 8'd0);
        send_tick(6'h00, 6'h3F, 3'd2);
        send_tick(6'h3F, 6'h15, 3'd0);
        program_ranger(16'd1, 16'd65535, 8'd1);
        send_tick(6'h00, 6'h3F, 3'd6);
        send_tick(6'h3F, 6'h3F, 3'd7);
        program_ranger(16'd1, 16'd2, 8'd1);
        for (int i = 0; i < 8; i++)
            send_tick(6'h00, 6'h3F, 3'(i));
    endtask

    task automatic test_fast_timebase();
        program_ranger(16'd1, 16'($urandom_range(0, 20)), 8'($urandom_range(1, 40)));
        random_ticks(250);
    endtask

    task automatic test_slow_timebase();
        program_ranger(16'($urandom_range(2, 6)), 16'($urandom_range(1, 8)), 8'd255);
        random_ticks(250);
    endtask

    task automatic test_backpressure();
        bit saved;
        drain_results();
        saved = src_idle_en;
        src_idle_en = 1'b0;
        hold_requests = hold_requests + 1;
        random_ticks(60);
        src_idle_en = saved;
        drain_results();
    endtask

    task automatic test_blocked_channels();
        program_ranger(16'd65535, 16'd65535, 8'($urandom_range(1, 255)));
        random_ticks(100);
    endtask

    task automatic test_long_echo();
        logic [NCH-1:0] req;
        program_ranger(mcur_pkg::TICKS_PER_MS_RESET, mcur_pkg::HOLDOFF_MS_RESET,
                       mcur_pkg::TRIGGER_WIDTH_TICKS_RESET);
        // hold channel 2 echo high for a long pulse, then drop it
        for (int i = 0; i < LONG_ECHO_TICKS; i++) begin
            req = ($urandom_range(0, 199) == 0) ? NCH'($urandom) : '0;
            send_tick(next_echo_levels() | 6'h04, req, 3'($urandom_range(0, 7)));
        end
        for (int i = 0; i < 5; i++)
            send_tick(next_echo_levels() & ~6'h04, 6'h00, 3'd2);
    endtask

    task automatic test_steady_stream();
        program_ranger(16'd2, 16'd5, 8'd8);
        random_ticks(200);
    endtask

    // Result sink with random stalls and on-demand long hold
    initial begin : result_sink
        int stall;
        int holds_served;
        holds_served = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_requests != holds_served) begin
                holds_served = hold_requests;
                m_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge aclk);
            end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 17);
                m_tready <= 1'b0;
                repeat (stall - 1) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic log_mismatch(input string what, input ranger_out_t want,
                                input ranger_out_t got);
        if (mismatches < 10)
            $display("%s: trig exp %h got %h, dist exp %0d got %0d, upd exp %h got %h",
                     what, want.trig, got.trig, want.dist_cm, got.dist_cm,
                     want.upd, got.upd);
        mismatches = mismatches + 1;
    endtask

    always @(posedge aclk) begin : check_out
        ranger_out_t got;
        ranger_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.trig    = m_tdata[NCH-1:0];
            got.dist_cm = m_tdata[NCH+mcur_pkg::DIST_BITS-1:NCH];
            got.upd     = m_tdata[2*NCH+mcur_pkg::DIST_BITS-1:NCH+mcur_pkg::DIST_BITS];
            if (expected_outs.size() == 0) begin
                log_mismatch("unexpected transfer", '0, got);
            end else begin
                want = expected_outs.pop_front();
                if (got.trig !== want.trig || got.dist_cm !== want.dist_cm ||
                    got.upd !== want.upd)
                    log_mismatch("result mismatch", want, got);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("multi_channel_ultrasonic_ranger_top verification failed");
            $finish;
        end
    end

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        for (int c = 0; c < NCH; c++) echo_hold[c] = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        reset_model();

        test_defaults();
        test_register_extremes();
        test_fast_timebase();
        test_slow_timebase();
        test_backpressure();
        test_blocked_channels();
        // no idling from here on
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        test_long_echo();
        test_steady_stream();
        drain_results();

        if (mismatches == 0 && expected_outs.size() == 0) begin
            $display("multi_channel_ultrasonic_ranger_top verification clean");
        end else begin
            $display("multi_channel_ultrasonic_ranger_top verification failed");
        end
        $finish;
    end

endmodule
